FILE: sv/toroidal_life_generation_step_top_assert.svh
// Assertion macros shared by the toroidal life generation step block.
`ifndef TOROIDAL_LIFE_GENERATION_STEP_TOP_ASSERT_SVH
`define TOROIDAL_LIFE_GENERATION_STEP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define TLGS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlgs same-cycle check failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define TLGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlgs next-cycle check failed");

`endif

FILE: sv/tlgs_pkg.sv
// Shared types and constants of the toroidal life generation step block.
package tlgs_pkg;

    // Field and port widths fixed by the item formats.
    localparam int ROW_FIELD_W = 6;
    localparam int COL_FIELD_W = 7;
    localparam int GEN_W       = 16;
    localparam int ROW_CNT_W   = 7;
    localparam int COL_CNT_W   = 8;
    localparam int IN_DATA_W   = 16;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 24;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int NBR_W       = 4;

    // Life rules.
    localparam logic [NBR_W-1:0] BIRTH_NEIGHBOURS = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_LOW      = 4'd2;
    localparam logic [NBR_W-1:0] SURVIVE_HIGH     = 4'd3;

    // Smallest board edge accepted by the count registers.
    localparam logic [ROW_CNT_W-1:0] ROW_COUNT_MIN = 7'd3;
    localparam logic [COL_CNT_W-1:0] COL_COUNT_MIN = 8'd3;

    // Item operations.
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } reg_idx_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic item_load;
        logic cell_write;
        logic result_load;
        logic result_read;
        logic adv_start;
        logic rd_up;
        logic rd_cur;
        logic rd_dn;
        logic cap_up;
        logic cap_cur;
        logic row_write;
        logic gen_step;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_row;
    } dp_status_t;

endpackage

FILE: sv/tlgs_row.sv
// Next-generation logic for one board row, one lane per column.
module tlgs_row #(
    parameter int MAX_COLUMNS = 128
) (
    input  logic [MAX_COLUMNS-1:0]          up_row,
    input  logic [MAX_COLUMNS-1:0]          cur_row,
    input  logic [MAX_COLUMNS-1:0]          dn_row,
    input  logic [tlgs_pkg::COL_CNT_W-1:0]  column_count,
    input  logic                            row_active,
    output logic [MAX_COLUMNS-1:0]          next_row
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int CW    = (COL_W > tlgs_pkg::COL_CNT_W) ? COL_W : tlgs_pkg::COL_CNT_W;

    logic [CW-1:0]    last_col;
    logic [COL_W-1:0] wrap_idx;
    logic             up_wrap;
    logic             cur_wrap;
    logic             dn_wrap;

    // The left neighbor of column zero is the last column in use.
    assign last_col = CW'(column_count) - CW'(1);
    assign wrap_idx = last_col[COL_W-1:0];
    assign up_wrap  = up_row[wrap_idx];
    assign cur_wrap = cur_row[wrap_idx];
    assign dn_wrap  = dn_row[wrap_idx];

    for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_lane
        logic             ul;
        logic             ur;
        logic             cl;
        logic             cr;
        logic             dl;
        logic             dr;
        logic             at_last;
        logic             active;
        logic             rule;
        logic [tlgs_pkg::NBR_W-1:0] cnt;

        assign at_last = (CW'(c) == last_col);
        assign active  = row_active && (CW'(c) <= last_col);

        // Left neighbors wrap at column zero.
        if (c == 0) begin : g_left_wrap
            assign ul = up_wrap;
            assign cl = cur_wrap;
            assign dl = dn_wrap;
        end
        else begin : g_left
            assign ul = up_row[c-1];
            assign cl = cur_row[c-1];
            assign dl = dn_row[c-1];
        end

        // Right neighbors wrap past the last column in use.
        if (c == MAX_COLUMNS - 1) begin : g_right_wrap
            assign ur = up_row[0];
            assign cr = cur_row[0];
            assign dr = dn_row[0];
        end
        else begin : g_right
            assign ur = at_last ? up_row[0]  : up_row[c+1];
            assign cr = at_last ? cur_row[0] : cur_row[c+1];
            assign dr = at_last ? dn_row[0]  : dn_row[c+1];
        end

        // Count the eight neighbors and apply the birth and survival rules.
        assign cnt = {3'b000, ul} + {3'b000, up_row[c]} + {3'b000, ur}
                   + {3'b000, cl} + {3'b000, cr}
                   + {3'b000, dl} + {3'b000, dn_row[c]} + {3'b000, dr};
        assign rule = cur_row[c] ? ((cnt == tlgs_pkg::SURVIVE_LOW) ||
                                    (cnt == tlgs_pkg::SURVIVE_HIGH))
                                 : (cnt == tlgs_pkg::BIRTH_NEIGHBOURS);

        // Cells outside the board in use keep their value.
        assign next_row[c] = active ? rule : cur_row[c];
    end

endmodule

FILE: sv/tlgs_dp.sv
// Datapath: the two board banks, row window, generation count and result register.
module tlgs_dp #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlgs_pkg::dp_cmd_t                 cmd,
    output tlgs_pkg::dp_status_t              status,
    input  logic [tlgs_pkg::ROW_FIELD_W-1:0]  item_row,
    input  logic [tlgs_pkg::COL_FIELD_W-1:0]  item_column,
    input  logic                              item_cell,
    input  logic [tlgs_pkg::ROW_CNT_W-1:0]    row_count,
    input  logic [tlgs_pkg::COL_CNT_W-1:0]    column_count,
    output logic                              cell_out,
    output logic [tlgs_pkg::GEN_W-1:0]        generation
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int RI_W  = (ROW_W > tlgs_pkg::ROW_FIELD_W) ? ROW_W : tlgs_pkg::ROW_FIELD_W;
    localparam int CI_W  = (COL_W > tlgs_pkg::COL_FIELD_W) ? COL_W : tlgs_pkg::COL_FIELD_W;
    localparam int RA_W  = ((ROW_W > tlgs_pkg::ROW_CNT_W) ? ROW_W : tlgs_pkg::ROW_CNT_W) + 1;

    // Board banks, one row per word; bank a rows read as dead until written.
    logic [MAX_COLUMNS-1:0] mem_a [MAX_ROWS];
    logic [MAX_COLUMNS-1:0] mem_b [MAX_ROWS];
    logic [MAX_ROWS-1:0]    vld_a_reg;

    logic [MAX_COLUMNS-1:0] a_q_reg;
    logic [MAX_COLUMNS-1:0] b_q_reg;
    logic                   a_vld_q_reg;
    logic [MAX_COLUMNS-1:0] rd_row;

    logic [MAX_COLUMNS-1:0] up_reg;
    logic [MAX_COLUMNS-1:0] cur_reg;
    logic [MAX_COLUMNS-1:0] next_row;
    logic [MAX_COLUMNS-1:0] cell_row;

    logic [ROW_W-1:0]       it_row_reg;
    logic [COL_W-1:0]       it_col_reg;
    logic                   it_cell_reg;
    logic                   it_inside_reg;

    logic [ROW_W-1:0]       row_idx_reg;
    logic [ROW_W-1:0]       row_idx_next;
    logic                   cur_bank_reg;
    logic [tlgs_pkg::GEN_W-1:0] gen_reg;
    logic                   cell_out_reg;
    logic [tlgs_pkg::GEN_W-1:0] gen_out_reg;

    logic [RI_W-1:0]        in_row_ext;
    logic [CI_W-1:0]        in_col_ext;
    logic                   in_inside;
    logic [RA_W-1:0]        ri;
    logic [RA_W-1:0]        rc;
    logic [RA_W-1:0]        up_full;
    logic [RA_W-1:0]        dn_full;
    logic                   row_active;

    logic                   rd_en;
    logic [ROW_W-1:0]       rd_addr;
    logic                   wr_to_a;
    logic                   wr_to_b;
    logic [ROW_W-1:0]       wr_addr;
    logic [MAX_COLUMNS-1:0] wr_data;

    // Item fields as storage indexes, and whether the cell lies in storage.
    assign in_row_ext = RI_W'(item_row);
    assign in_col_ext = CI_W'(item_column);
    assign in_inside  = (int'(item_row) < MAX_ROWS) && (int'(item_column) < MAX_COLUMNS);

    // Wrapped neighbor rows of the row being computed.
    assign ri         = RA_W'(row_idx_reg);
    assign rc         = RA_W'(row_count);
    assign up_full    = (row_idx_reg == '0) ? (rc - RA_W'(1)) : (ri - RA_W'(1));
    assign dn_full    = ((ri + RA_W'(1)) >= rc) ? '0 : (ri + RA_W'(1));
    assign row_active = (ri < rc);

    // Read address selection.
    assign rd_en = cmd.item_load || cmd.rd_up || cmd.rd_cur || cmd.rd_dn;
    always_comb
    begin
        priority if (cmd.item_load)
        begin
            rd_addr = in_row_ext[ROW_W-1:0];
        end
        else if (cmd.rd_up)
        begin
            rd_addr = up_full[ROW_W-1:0];
        end
        else if (cmd.rd_dn)
        begin
            rd_addr = dn_full[ROW_W-1:0];
        end
        else
        begin
            rd_addr = row_idx_reg;
        end
    end

    // Current-bank row from the most recent registered read.
    assign rd_row = cur_bank_reg ? b_q_reg : (a_vld_q_reg ? a_q_reg : '0);

    // Read-modify-write row for a cell write.
    always_comb
    begin
        cell_row             = rd_row;
        cell_row[it_col_reg] = it_cell_reg;
    end

    // A cell write goes to the current bank, a new row to the other bank.
    assign wr_to_a = (cmd.cell_write && it_inside_reg && !cur_bank_reg) ||
                     (cmd.row_write && cur_bank_reg);
    assign wr_to_b = (cmd.cell_write && it_inside_reg && cur_bank_reg) ||
                     (cmd.row_write && !cur_bank_reg);
    assign wr_addr = cmd.row_write ? row_idx_reg : it_row_reg;
    assign wr_data = cmd.row_write ? next_row : cell_row;

    // Bank a storage with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_to_a)
        begin
            mem_a[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            a_q_reg     <= mem_a[rd_addr];
            a_vld_q_reg <= vld_a_reg[rd_addr];
        end
    end

    // Bank b storage with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_to_b)
        begin
            mem_b[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            b_q_reg <= mem_b[rd_addr];
        end
    end

    // Per-row written marks of bank a.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= '0;
        end
        else if (wr_to_a)
        begin
            vld_a_reg[wr_addr] <= 1'b1;
        end
    end

    // Item fields and the three-row window.
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            it_row_reg    <= in_row_ext[ROW_W-1:0];
            it_col_reg    <= in_col_ext[COL_W-1:0];
            it_cell_reg   <= item_cell;
            it_inside_reg <= in_inside;
        end
        if (cmd.cap_up)
        begin
            up_reg <= rd_row;
        end
        if (cmd.cap_cur)
        begin
            cur_reg <= rd_row;
        end
    end

    // Next-generation row from the window; the lower row comes straight from the read.
    tlgs_row #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_row (
        .up_row       (up_reg),
        .cur_row      (cur_reg),
        .dn_row       (rd_row),
        .column_count (column_count),
        .row_active   (row_active),
        .next_row     (next_row)
    );

    // Row sweep counter.
    always_comb
    begin
        row_idx_next = row_idx_reg;
        if (cmd.adv_start)
        begin
            row_idx_next = '0;
        end
        else if (cmd.row_write)
        begin
            row_idx_next = row_idx_reg + ROW_W'(1);
        end
    end

    // Sweep counter, bank select and generation count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_idx_reg  <= '0;
            cur_bank_reg <= 1'b0;
            gen_reg      <= '0;
        end
        else
        begin
            row_idx_reg <= row_idx_next;
            if (cmd.gen_step)
            begin
                cur_bank_reg <= !cur_bank_reg;
                gen_reg      <= gen_reg + tlgs_pkg::GEN_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            cell_out_reg <= cmd.result_read && it_inside_reg && rd_row[it_col_reg];
            gen_out_reg  <= cmd.gen_step ? (gen_reg + tlgs_pkg::GEN_W'(1)) : gen_reg;
        end
    end

    assign status.last_row = (row_idx_reg == ROW_W'(MAX_ROWS - 1));
    assign cell_out        = cell_out_reg;
    assign generation      = gen_out_reg;

endmodule

FILE: sv/tlgs_ctrl.sv
// Controller: item handshake, operation sequencing and result valid.
module tlgs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tlgs_pkg::op_t         in_op,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tlgs_pkg::dp_cmd_t     cmd,
    input  tlgs_pkg::dp_status_t  status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CELL,
        S_UP,
        S_CUR,
        S_DN,
        S_WR,
        S_FIN
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    tlgs_pkg::op_t op_reg;
    tlgs_pkg::op_t op_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    op_next       = in_op;
                    if (in_op == tlgs_pkg::OP_ADVANCE)
                    begin
                        cmd.adv_start = 1'b1;
                        state_next    = S_UP;
                    end
                    else
                    begin
                        state_next = S_CELL;
                    end
                end
            end
            S_CELL:
            begin
                if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    cmd.result_read = (op_reg == tlgs_pkg::OP_READ);
                    cmd.cell_write  = (op_reg == tlgs_pkg::OP_WRITE);
                    state_next      = S_IDLE;
                end
            end
            S_UP:
            begin
                cmd.rd_up  = 1'b1;
                state_next = S_CUR;
            end
            S_CUR:
            begin
                cmd.cap_up = 1'b1;
                cmd.rd_cur = 1'b1;
                state_next = S_DN;
            end
            S_DN:
            begin
                cmd.cap_cur = 1'b1;
                cmd.rd_dn   = 1'b1;
                state_next  = S_WR;
            end
            S_WR:
            begin
                cmd.row_write = 1'b1;
                state_next    = status.last_row ? S_FIN : S_UP;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    cmd.gen_step    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = cmd.result_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= tlgs_pkg::OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/toroidal_life_generation_step_top.sv
// Top level of the toroidal life generation step block.
//
//   Channel   Signals                              Transaction
//   config    psel penable pwrite paddr pwdata     register write or read, APB style
//   input     s_tvalid s_tready s_tdata s_tuser    one item: write, read or advance
//   output    m_tvalid m_tready m_tdata            one result per item
//
// A cell write or read first reads the row word, then merges or picks the bit.
// An advance sweeps every storage row: each row needs three reads of the single read
// port of the current bank plus one write of the new row into the other bank.
// Reset is asynchronous; bank a reads as dead through per-row written marks, no clearing pass.
// A finished result waits in the output register while the next item is accepted; that
// item completes only once the register is free.
`include "toroidal_life_generation_step_top_assert.svh"

module toroidal_life_generation_step_top #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tlgs_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [tlgs_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [tlgs_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    // Input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tlgs_pkg::IN_DATA_W-1:0]     s_tdata,   // row[5:0], column[12:6], cell_in[13]
    input  logic [tlgs_pkg::IN_USER_W-1:0]     s_tuser,   // operation[1:0]
    // Results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tlgs_pkg::OUT_DATA_W-1:0]    m_tdata    // cell_out[0], generation[16:1]
);

    localparam logic [tlgs_pkg::ROW_CNT_W-1:0] ROW_RESET =
        tlgs_pkg::ROW_CNT_W'((MAX_ROWS < 64) ? MAX_ROWS : 64);
    localparam logic [tlgs_pkg::COL_CNT_W-1:0] COL_RESET =
        tlgs_pkg::COL_CNT_W'((MAX_COLUMNS < 128) ? MAX_COLUMNS : 128);

    logic                              cfg_write;
    tlgs_pkg::reg_idx_t                cfg_sel;
    logic [tlgs_pkg::ROW_CNT_W-1:0]    row_count_reg;
    logic [tlgs_pkg::ROW_CNT_W-1:0]    row_count_next;
    logic [tlgs_pkg::COL_CNT_W-1:0]    column_count_reg;
    logic [tlgs_pkg::COL_CNT_W-1:0]    column_count_next;
    logic [tlgs_pkg::ROW_CNT_W-1:0]    row_wr;
    logic [tlgs_pkg::COL_CNT_W-1:0]    col_wr;

    tlgs_pkg::dp_cmd_t                 dp_cmd;
    tlgs_pkg::dp_status_t              dp_status;
    logic                              cell_out;
    logic [tlgs_pkg::GEN_W-1:0]        generation;

    // Configuration writes complete in the access cycle; no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = tlgs_pkg::reg_idx_t'(paddr[2]);
    assign row_wr    = pwdata[tlgs_pkg::ROW_CNT_W-1:0];
    assign col_wr    = pwdata[tlgs_pkg::COL_CNT_W-1:0];

    // Written counts are saturated into the board that storage holds.
    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        if (cfg_write && (cfg_sel == tlgs_pkg::REG_ROW_COUNT))
        begin
            priority if (row_wr < tlgs_pkg::ROW_COUNT_MIN)
            begin
                row_count_next = tlgs_pkg::ROW_COUNT_MIN;
            end
            else if (int'(row_wr) > MAX_ROWS)
            begin
                row_count_next = tlgs_pkg::ROW_CNT_W'(MAX_ROWS);
            end
            else
            begin
                row_count_next = row_wr;
            end
        end
        if (cfg_write && (cfg_sel == tlgs_pkg::REG_COLUMN_COUNT))
        begin
            priority if (col_wr < tlgs_pkg::COL_COUNT_MIN)
            begin
                column_count_next = tlgs_pkg::COL_COUNT_MIN;
            end
            else if (int'(col_wr) > MAX_COLUMNS)
            begin
                column_count_next = tlgs_pkg::COL_CNT_W'(MAX_COLUMNS);
            end
            else
            begin
                column_count_next = col_wr;
            end
        end
    end

    // Board size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROW_RESET;
            column_count_reg <= COL_RESET;
        end
        else
        begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_sel)
            tlgs_pkg::REG_ROW_COUNT:
            begin
                prdata = tlgs_pkg::CFG_DATA_W'(row_count_reg);
            end
            tlgs_pkg::REG_COLUMN_COUNT:
            begin
                prdata = tlgs_pkg::CFG_DATA_W'(column_count_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // Sequencing of items.
    tlgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (tlgs_pkg::op_t'(s_tuser)),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    // Board storage and generation logic.
    tlgs_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .item_row     (s_tdata[5:0]),
        .item_column  (s_tdata[12:6]),
        .item_cell    (s_tdata[13]),
        .row_count    (row_count_reg),
        .column_count (column_count_reg),
        .cell_out     (cell_out),
        .generation   (generation)
    );

    assign m_tdata = {7'b0000000, generation, cell_out};

    // A new result never overwrites one that is still waiting.
    `TLGS_ASSERT_IMPL(a_no_overwrite, dp_cmd.result_load, !m_tvalid || m_tready)
    // The bank flip and generation increment come with the advance result.
    `TLGS_ASSERT_IMPL(a_gen_with_result, dp_cmd.gen_step, dp_cmd.result_load)
    // Only one item is in work at a time.
    `TLGS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
    // No item is taken while a generation sweep is running.
    `TLGS_ASSERT_IMPL(a_sweep_busy, dp_cmd.row_write || dp_cmd.cap_up, !s_tready)

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the toroidal life generation step block.
`timescale 1ns / 1ps

module tb;

    localparam int BOARD_ROWS     = 64;
    localparam int BOARD_COLUMNS  = 128;
    localparam int ADVANCE_CYCLES = 4 * BOARD_ROWS + 2;
    localparam int SETTLE_CYCLES  = ADVANCE_CYCLES + 40;
    localparam int HOLD_OFF       = 3 * ADVANCE_CYCLES;
    localparam int WATCHDOG_LIMIT = 20 * ADVANCE_CYCLES;

    localparam logic [tlgs_pkg::CFG_ADDR_W-1:0] ROW_COUNT_ADDR =
        {tlgs_pkg::REG_ROW_COUNT, 2'b00};
    localparam logic [tlgs_pkg::CFG_ADDR_W-1:0] COLUMN_COUNT_ADDR =
        {tlgs_pkg::REG_COLUMN_COUNT, 2'b00};

    typedef struct {
        logic        cell_out;
        logic [15:0] generation;
    } life_result_t;

    // Keeps a private copy of both board banks and predicts each result.
    class life_board_scoreboard;
        bit [BOARD_COLUMNS-1:0] bank [2][BOARD_ROWS];
        bit                     cur;
        bit [15:0]              gen_count;
        int                     rows_used;
        int                     cols_used;
        life_result_t           expected_results[$];
        int                     errors;

        function new();
            cur       = 1'b0;
            gen_count = '0;
            rows_used = BOARD_ROWS;
            cols_used = BOARD_COLUMNS;
            errors    = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function int clamp_count(logic [31:0] v, int hi);
            if (v < 3)
                return 3;
            if (v > hi)
                return hi;
            return int'(v);
        endfunction

        // Mirror a register write, saturated into the legal range.
        function void set_register(logic [tlgs_pkg::CFG_ADDR_W-1:0] addr, logic [31:0] data);
            if (addr == ROW_COUNT_ADDR)
                rows_used = clamp_count(data & 32'h7F, BOARD_ROWS);
            else if (addr == COLUMN_COUNT_ADDR)
                cols_used = clamp_count(data & 32'hFF, BOARD_COLUMNS);
        endfunction

        // Compute the next generation into the other bank and swap.
        function void step_generation();
            int rs[3];
            int cs[3];
            int n;
            bit live;
            bit nb;
            nb = ~cur;
            for (int r = 0; r < BOARD_ROWS; r++)
                bank[nb][r] = bank[cur][r];
            for (int r = 0; r < rows_used; r++)
            begin
                rs[0] = (r == 0) ? rows_used - 1 : r - 1;
                rs[1] = r;
                rs[2] = (r + 1 >= rows_used) ? 0 : r + 1;
                for (int c = 0; c < cols_used; c++)
                begin
                    cs[0] = (c == 0) ? cols_used - 1 : c - 1;
                    cs[1] = c;
                    cs[2] = (c + 1 >= cols_used) ? 0 : c + 1;
                    n = 0;
                    for (int i = 0; i < 3; i++)
                        for (int j = 0; j < 3; j++)
                            if (!(i == 1 && j == 1))
                                n += bank[cur][rs[i]][cs[j]];
                    live = bank[cur][r][c];
                    if (live)
                        bank[nb][r][c] = (n >= tlgs_pkg::SURVIVE_LOW &&
                                          n <= tlgs_pkg::SURVIVE_HIGH);
                    else
                        bank[nb][r][c] = (n == tlgs_pkg::BIRTH_NEIGHBOURS);
                end
            end
            cur = nb;
            gen_count++;
        endfunction

        // Apply one accepted input transaction and queue its result.
        function void note_item(tlgs_pkg::op_t op, logic [5:0] r, logic [6:0] c, logic v);
            life_result_t res;
            res.cell_out = 1'b0;
            unique case (op)
                tlgs_pkg::OP_WRITE:   bank[cur][r][c] = v;
                tlgs_pkg::OP_READ:    res.cell_out = bank[cur][r][c];
                tlgs_pkg::OP_ADVANCE: step_generation();
                default:              ;
            endcase
            res.generation = gen_count;
            expected_results.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Compare one accepted output transaction with the oldest prediction.
        task check_result(logic [tlgs_pkg::OUT_DATA_W-1:0] d);
            life_result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", d));
                return;
            end
            want = expected_results.pop_front();
            if (d[0] !== want.cell_out)
                report_mismatch($sformatf("cell_out got %b want %b", d[0], want.cell_out));
            if (d[16:1] !== want.generation)
                report_mismatch($sformatf("generation got %0d want %0d",
                                          d[16:1], want.generation));
        endtask
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [tlgs_pkg::CFG_ADDR_W-1:0] paddr;
    logic [tlgs_pkg::CFG_DATA_W-1:0] pwdata;
    logic [tlgs_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [tlgs_pkg::IN_DATA_W-1:0]  s_tdata;   // row[5:0], column[12:6], cell_in[13]
    logic [tlgs_pkg::IN_USER_W-1:0]  s_tuser;   // operation[1:0]
    logic                            m_tvalid;
    logic                            m_tready;
    logic [tlgs_pkg::OUT_DATA_W-1:0] m_tdata;   // cell_out[0], generation[16:1]

    life_board_scoreboard sb = new();

    bit sender_gaps      = 1'b1;
    bit receiver_stalls  = 1'b1;
    bit hold_off_request = 1'b0;
    int items_sent       = 0;
    int idle_cycles      = 0;

    toroidal_life_generation_step_top #(
        .MAX_ROWS    (BOARD_ROWS),
        .MAX_COLUMNS (BOARD_COLUMNS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        bit ready_next;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF;
            end
            else if (hold_left == 0 && receiver_stalls && $urandom_range(0, 5) == 0)
                hold_left = $urandom_range(1, 9);
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
                ready_next = 1'b1;
            m_tready <= ready_next;
        end
    end

    // Check every output transaction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog on cycles with no transaction on any channel.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One register access: setup cycle, then access until pready.
    task automatic apb_access(bit wr, logic [tlgs_pkg::CFG_ADDR_W-1:0] addr,
                              logic [31:0] data);
        int want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (wr)
            sb.set_register(addr, data);
        else
        begin
            want = (addr == ROW_COUNT_ADDR) ? sb.rows_used : sb.cols_used;
            if (prdata !== want)
                sb.report_mismatch($sformatf("register %0d read %0d want %0d",
                                             addr, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one input transaction, with an optional gap before it.
    task automatic send_item(tlgs_pkg::op_t op, int r, int c, int v);
        logic [5:0] row_f;
        logic [6:0] col_f;
        logic       cell_f;
        row_f  = 6'(r);
        col_f  = 7'(c);
        cell_f = 1'(v);
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, cell_f, col_f, row_f};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        sb.note_item(op, row_f, col_f, cell_f);
        items_sent++;
    endtask

    // Mostly well-formed patterns followed by generations and reads, with some noise.
    task automatic random_items(int n);
        int target;
        int rows;
        int cols;
        int r0;
        int c0;
        int r;
        int c;
        int glider_r[5];
        int glider_c[5];
        glider_r = '{0, 1, 2, 2, 2};
        glider_c = '{1, 2, 0, 1, 2};
        target = items_sent + n;
        while (items_sent < target)
        begin
            rows = sb.rows_used;
            cols = sb.cols_used;
            r0 = $urandom_range(0, rows - 1);
            c0 = $urandom_range(0, cols - 1);
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    // Random cluster, then a few generations with reads nearby.
                    repeat ($urandom_range(3, 12))
                        send_item(tlgs_pkg::OP_WRITE, (r0 + $urandom_range(0, 3)) % rows,
                                  (c0 + $urandom_range(0, 3)) % cols,
                                  $urandom_range(0, 4) != 0);
                    repeat ($urandom_range(1, 4))
                    begin
                        send_item(tlgs_pkg::OP_ADVANCE, $urandom_range(0, 63),
                                  $urandom_range(0, 127), $urandom_range(0, 1));
                        send_item(tlgs_pkg::OP_READ, (r0 + $urandom_range(0, 4)) % rows,
                                  (c0 + $urandom_range(0, 4)) % cols, $urandom_range(0, 1));
                    end
                end
                3:
                begin
                    // Glider, wrapping across the board edges as it moves.
                    for (int k = 0; k < 5; k++)
                        send_item(tlgs_pkg::OP_WRITE, (r0 + glider_r[k]) % rows,
                                  (c0 + glider_c[k]) % cols, 1);
                    repeat ($urandom_range(2, 6))
                    begin
                        send_item(tlgs_pkg::OP_ADVANCE, $urandom_range(0, 63),
                                  $urandom_range(0, 127), $urandom_range(0, 1));
                        repeat (2)
                            send_item(tlgs_pkg::OP_READ, (r0 + $urandom_range(0, 4)) % rows,
                                      (c0 + $urandom_range(0, 4)) % cols, 0);
                    end
                end
                4, 5:
                    repeat ($urandom_range(1, 6))
                        send_item(tlgs_pkg::OP_READ, $urandom_range(0, rows - 1),
                                  $urandom_range(0, cols - 1), $urandom_range(0, 1));
                6:
                begin
                    // Cell in storage but outside the board in use, where that board is smaller, survives advances.
                    r = (rows < BOARD_ROWS) ? $urandom_range(rows, BOARD_ROWS - 1)
                                            : $urandom_range(0, BOARD_ROWS - 1);
                    c = (cols < BOARD_COLUMNS) ? $urandom_range(cols, BOARD_COLUMNS - 1)
                                               : $urandom_range(0, BOARD_COLUMNS - 1);
                    send_item(tlgs_pkg::OP_WRITE, r, c, $urandom_range(0, 1));
                    send_item(tlgs_pkg::OP_READ, r, c, $urandom_range(0, 1));
                    send_item(tlgs_pkg::OP_ADVANCE, r, c, $urandom_range(0, 1));
                    send_item(tlgs_pkg::OP_READ, r, c, $urandom_range(0, 1));
                end
                7:
                    repeat ($urandom_range(1, 4))
                        send_item(tlgs_pkg::op_t'($urandom_range(0, 3)),
                                  $urandom_range(0, 63), $urandom_range(0, 127),
                                  $urandom_range(0, 1));
                8:
                begin
                    // Clear part of a region and read it back.
                    repeat ($urandom_range(2, 6))
                        send_item(tlgs_pkg::OP_WRITE, (r0 + $urandom_range(0, 2)) % rows,
                                  (c0 + $urandom_range(0, 2)) % cols, 0);
                    send_item(tlgs_pkg::OP_READ, r0, c0, 1);
                end
                default:
                begin
                    send_item(tlgs_pkg::OP_ADVANCE, $urandom_range(0, 63),
                              $urandom_range(0, 127), $urandom_range(0, 1));
                    send_item(tlgs_pkg::OP_READ, $urandom_range(0, 63),
                              $urandom_range(0, 127), $urandom_range(0, 1));
                end
            endcase
        end
    endtask

    // Reconfigure the board once the block is idle, then run random traffic.
    task automatic run_phase(logic [31:0] rows_val, logic [31:0] cols_val, int n,
                             bit pressure);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        apb_access(1'b1, ROW_COUNT_ADDR, rows_val);
        apb_access(1'b1, COLUMN_COUNT_ADDR, cols_val);
        apb_access(1'b0, ROW_COUNT_ADDR, '0);
        apb_access(1'b0, COLUMN_COUNT_ADDR, '0);
        if (pressure)
            hold_off_request = 1'b1;
        random_items(n);
    endtask

    // Main sequence.
    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= tlgs_pkg::OP_NONE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of the count registers.
        apb_access(1'b0, ROW_COUNT_ADDR, '0);
        apb_access(1'b0, COLUMN_COUNT_ADDR, '0);

        // Directed: corners of the full board, wrap-around neighbours, a blinker,
        // the unused operation and all-ones fields.
        send_item(tlgs_pkg::OP_READ, 0, 0, 1);
        send_item(tlgs_pkg::OP_WRITE, 0, 0, 1);
        send_item(tlgs_pkg::OP_WRITE, 63, 127, 1);
        send_item(tlgs_pkg::OP_WRITE, 0, 127, 1);
        send_item(tlgs_pkg::OP_READ, 0, 0, 0);
        send_item(tlgs_pkg::OP_READ, 63, 127, 0);
        send_item(tlgs_pkg::OP_READ, 63, 0, 0);
        send_item(tlgs_pkg::OP_ADVANCE, 0, 0, 0);
        send_item(tlgs_pkg::OP_READ, 63, 0, 0);
        send_item(tlgs_pkg::OP_READ, 0, 127, 0);
        send_item(tlgs_pkg::OP_NONE, 63, 127, 1);
        send_item(tlgs_pkg::OP_WRITE, 10, 10, 1);
        send_item(tlgs_pkg::OP_WRITE, 10, 11, 1);
        send_item(tlgs_pkg::OP_WRITE, 10, 12, 1);
        send_item(tlgs_pkg::OP_ADVANCE, 63, 127, 1);
        send_item(tlgs_pkg::OP_READ, 9, 11, 0);
        send_item(tlgs_pkg::OP_READ, 11, 11, 0);
        send_item(tlgs_pkg::OP_READ, 10, 10, 0);
        send_item(tlgs_pkg::OP_ADVANCE, 0, 0, 0);
        send_item(tlgs_pkg::OP_READ, 10, 12, 1);
        send_item(tlgs_pkg::OP_WRITE, 0, 0, 0);
        send_item(tlgs_pkg::OP_READ, 0, 0, 0);
        send_item(tlgs_pkg::OP_NONE, 0, 0, 0);

        run_phase(32'd3, 32'd3, 200, 1'b0);
        run_phase(32'd0, 32'hFF, 150, 1'b0);
        run_phase(32'd127, 32'd2, 150, 1'b0);
        run_phase(32'd8, 32'd10, 250, 1'b1);
        run_phase(32'hFFFF_FF10, 32'h0001_0014, 250, 1'b0);
        run_phase(32'd64, 32'd128, 200, 1'b0);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        run_phase(32'd5, 32'd7, 200, 1'b0);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
